@@ hw/rtl/calculator_token_scanner_core_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef CALCULATOR_TOKEN_SCANNER_CORE_MACROS_SVH
`define CALCULATOR_TOKEN_SCANNER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ctscan_pkg.sv @@
`timescale 1ns / 1ps

package ctscan_pkg;

    localparam int MAX_TOKEN_LEN = 99;
    localparam int CNT_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int MODE_W        = 3;

    localparam logic [MODE_W-1:0] M_IDLE    = 3'd0;
    localparam logic [MODE_W-1:0] M_IDENT   = 3'd1;
    localparam logic [MODE_W-1:0] M_LIT     = 3'd2;
    localparam logic [MODE_W-1:0] M_COLON   = 3'd3;
    localparam logic [MODE_W-1:0] M_DOLLAR  = 3'd4;
    localparam logic [MODE_W-1:0] M_EQUAL   = 3'd5;
    localparam logic [MODE_W-1:0] M_LESS    = 3'd6;
    localparam logic [MODE_W-1:0] M_GREATER = 3'd7;

    localparam logic [4:0] K_ID   = 5'd7;
    localparam logic [4:0] K_LIT  = 5'd8;
    localparam logic [4:0] K_GETS = 5'd9;
    localparam logic [4:0] K_EQEQ = 5'd10;
    localparam logic [4:0] K_NE   = 5'd11;
    localparam logic [4:0] K_LE   = 5'd12;
    localparam logic [4:0] K_LT   = 5'd13;
    localparam logic [4:0] K_GE   = 5'd14;
    localparam logic [4:0] K_GT   = 5'd15;
    localparam logic [4:0] K_ADD  = 5'd16;
    localparam logic [4:0] K_SUB  = 5'd17;
    localparam logic [4:0] K_MUL  = 5'd18;
    localparam logic [4:0] K_DIV  = 5'd19;
    localparam logic [4:0] K_LP   = 5'd20;
    localparam logic [4:0] K_RP   = 5'd21;
    localparam logic [4:0] K_EOF  = 5'd22;
    localparam logic [4:0] K_ERR  = 5'd23;

    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_BAD_PAIR = 2'd1;
    localparam logic [1:0] E_BAD_CHAR = 2'd2;
    localparam logic [1:0] E_TOO_LONG = 2'd3;

    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_DOLLAR     = 8'h24;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_LESS       = 8'h3C;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    // Keyword text, first character in the low byte.
    localparam logic [39:0] KW_TEXT [7] = '{
        40'h00_64_61_65_72,
        40'h65_74_69_72_77,
        40'h00_00_00_66_69,
        40'h00_00_00_6F_64,
        40'h00_00_00_69_66,
        40'h00_00_00_64_6F,
        40'h6B_63_65_68_63
    };
    localparam logic [CNT_W-1:0] KW_LEN [7] = '{
        CNT_W'(4), CNT_W'(5), CNT_W'(2), CNT_W'(2), CNT_W'(2), CNT_W'(2), CNT_W'(5)
    };

    typedef struct packed {
        logic [4:0] kind;
        logic [6:0] length;
        logic [1:0] code;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              fire;
        logic [4:0]        kind;
        logic [1:0]        code;
        logic              halt;
    } idle_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
    endfunction

    function automatic result_t make_result(input logic [4:0] kind,
                                            input logic [6:0] length,
                                            input logic [1:0] code);
        result_t r;
        r.kind   = kind;
        r.length = length;
        r.code   = code;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic logic [4:0] kw_kind(input logic [39:0] prefix,
                                           input logic [CNT_W-1:0] count);
        logic [4:0] kind;
        kind = K_ID;
        for (int k = 6; k >= 0; k--) begin
            if (count == KW_LEN[k] && prefix == KW_TEXT[k]) begin
                kind = 5'(k);
            end
        end
        return kind;
    endfunction

    function automatic idle_t scan_idle(input logic [7:0] c);
        idle_t s;
        s.mode = M_IDLE;
        s.fire = 1'b0;
        s.kind = K_ERR;
        s.code = E_NONE;
        s.halt = 1'b0;
        if (is_space(c)) begin
            s.fire = 1'b0;
        end else if (is_letter(c)) begin
            s.mode = M_IDENT;
        end else if (is_digit(c)) begin
            s.mode = M_LIT;
        end else begin
            case (c)
                CH_COLON:   s.mode = M_COLON;
                CH_DOLLAR:  s.mode = M_DOLLAR;
                CH_EQUAL:   s.mode = M_EQUAL;
                CH_LESS:    s.mode = M_LESS;
                CH_GREATER: s.mode = M_GREATER;
                CH_PLUS:    begin s.fire = 1'b1; s.kind = K_ADD; end
                CH_MINUS:   begin s.fire = 1'b1; s.kind = K_SUB; end
                CH_STAR:    begin s.fire = 1'b1; s.kind = K_MUL; end
                CH_SLASH:   begin s.fire = 1'b1; s.kind = K_DIV; end
                CH_LPAREN:  begin s.fire = 1'b1; s.kind = K_LP; end
                CH_RPAREN:  begin s.fire = 1'b1; s.kind = K_RP; end
                default:
                begin
                    s.fire = 1'b1;
                    s.kind = K_ERR;
                    s.code = E_BAD_CHAR;
                    s.halt = 1'b1;
                end
            endcase
        end
        return s;
    endfunction

endpackage

@@ hw/rtl/calculator_token_scanner_core.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in        sink       in_valid/in_stall  input_byte, end_of_input
// out       source     out_valid/out_stall token_kind, token_length, error_code, last_result
//
// One byte is taken per cycle while in_stall is low; each byte yields zero, one or two tokens.
// A byte passes through the input register, the scan logic and a four-entry token queue.
// Output runs at one token per cycle while out_stall is low; the input stalls while
// a byte waits in the input register and the queue holds three or more.
// Reset clears the scan state, the halt flag, the input register's full flag and the queue count and pointers.
module calculator_token_scanner_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] input_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] token_kind,
    output logic [6:0] token_length,
    output logic [1:0] error_code,
    output logic       last_result
);
    import ctscan_pkg::*;

    logic                in_full_reg;
    logic                in_full_next;
    logic [7:0]          byte_reg;
    logic                eoi_reg;

    logic [MODE_W-1:0]   mode_reg;
    logic [MODE_W-1:0]   mode_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [39:0]         pre_reg;
    logic [39:0]         pre_next;
    logic                halt_reg;
    logic                halt_next;

    result_t             fifo_reg [4];
    logic [1:0]          head_reg;
    logic [1:0]          head_next;
    logic [1:0]          tail_reg;
    logic [1:0]          tail_next;
    logic [2:0]          count_reg;
    logic [2:0]          count_next;

    logic                accept;
    logic                proc;
    logic                pop;
    idle_t               idl;
    logic                use_idle;
    logic                fa_v;
    logic                fb_v;
    result_t             fa;
    result_t             fb;
    result_t             r0;
    result_t             r1;
    logic [1:0]          n_push;
    logic [6:0]          cur_len;

    assign in_stall  = in_full_reg && (count_reg > 3'd2);
    assign accept    = in_valid && !in_stall;
    assign proc      = in_full_reg && (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && !out_stall;
    assign cur_len   = 7'(cnt_reg);

    assign token_kind   = fifo_reg[head_reg].kind;
    assign token_length = fifo_reg[head_reg].length;
    assign error_code   = fifo_reg[head_reg].code;
    assign last_result  = fifo_reg[head_reg].last;

    assign in_full_next = accept ? 1'b1 : (proc ? 1'b0 : in_full_reg);

    always_comb
    begin
        idl       = scan_idle(byte_reg);
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        pre_next  = pre_reg;
        halt_next = halt_reg;
        use_idle  = 1'b0;
        fa_v      = 1'b0;
        fb_v      = 1'b0;
        fa        = '0;
        fb        = '0;
        if (proc && !halt_reg) begin
            if (eoi_reg) begin
                mode_next = M_IDLE;
                case (mode_reg)
                    M_IDENT:
                    begin
                        fa_v = 1'b1;
                        fa   = make_result(kw_kind(pre_reg, cnt_reg), cur_len, E_NONE);
                    end
                    M_LIT:
                    begin
                        fa_v = 1'b1;
                        fa   = make_result(K_LIT, cur_len, E_NONE);
                    end
                    M_LESS:
                    begin
                        fa_v = 1'b1;
                        fa   = make_result(K_LT, 7'd0, E_NONE);
                    end
                    M_GREATER:
                    begin
                        fa_v = 1'b1;
                        fa   = make_result(K_GT, 7'd0, E_NONE);
                    end
                    M_COLON, M_DOLLAR, M_EQUAL:
                    begin
                        fa_v      = 1'b1;
                        fa        = make_result(K_ERR, 7'd0, E_BAD_PAIR);
                        halt_next = 1'b1;
                    end
                    default: ;
                endcase
                if (!halt_next) begin
                    fb_v = 1'b1;
                    fb   = make_result(K_EOF, 7'd0, E_NONE);
                end
            end else begin
                case (mode_reg)
                    M_IDENT, M_LIT:
                    begin
                        if (is_digit(byte_reg) || ((mode_reg == M_IDENT) &&
                            (is_letter(byte_reg) || byte_reg == CH_UNDERSCORE))) begin
                            if (cnt_reg >= CNT_W'(MAX_TOKEN_LEN)) begin
                                fa_v      = 1'b1;
                                fa        = make_result(K_ERR, 7'd0, E_TOO_LONG);
                                halt_next = 1'b1;
                                mode_next = M_IDLE;
                            end else begin
                                if (cnt_reg < CNT_W'(5)) begin
                                    pre_next[{cnt_reg[2:0], 3'b000} +: 8] = byte_reg;
                                end
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end else begin
                            fa_v     = 1'b1;
                            fa       = (mode_reg == M_IDENT)
                                     ? make_result(kw_kind(pre_reg, cnt_reg), cur_len, E_NONE)
                                     : make_result(K_LIT, cur_len, E_NONE);
                            use_idle = 1'b1;
                        end
                    end
                    M_COLON, M_DOLLAR, M_EQUAL:
                    begin
                        fa_v      = 1'b1;
                        mode_next = M_IDLE;
                        if (mode_reg == M_COLON && byte_reg == CH_EQUAL) begin
                            fa = make_result(K_GETS, 7'd0, E_NONE);
                        end else if (mode_reg == M_EQUAL && byte_reg == CH_EQUAL) begin
                            fa = make_result(K_EQEQ, 7'd0, E_NONE);
                        end else if (mode_reg == M_DOLLAR && byte_reg == CH_DOLLAR) begin
                            fa = make_result(K_EOF, 7'd0, E_NONE);
                        end else begin
                            fa        = make_result(K_ERR, 7'd0, E_BAD_PAIR);
                            halt_next = 1'b1;
                        end
                    end
                    M_LESS:
                    begin
                        fa_v      = 1'b1;
                        mode_next = M_IDLE;
                        if (byte_reg == CH_GREATER) begin
                            fa = make_result(K_NE, 7'd0, E_NONE);
                        end else if (byte_reg == CH_EQUAL) begin
                            fa = make_result(K_LE, 7'd0, E_NONE);
                        end else begin
                            fa       = make_result(K_LT, 7'd0, E_NONE);
                            use_idle = 1'b1;
                        end
                    end
                    M_GREATER:
                    begin
                        fa_v      = 1'b1;
                        mode_next = M_IDLE;
                        if (byte_reg == CH_EQUAL) begin
                            fa = make_result(K_GE, 7'd0, E_NONE);
                        end else begin
                            fa       = make_result(K_GT, 7'd0, E_NONE);
                            use_idle = 1'b1;
                        end
                    end
                    default: use_idle = 1'b1;
                endcase
            end
        end
        if (use_idle) begin
            mode_next = idl.mode;
            fb_v      = idl.fire;
            fb        = make_result(idl.kind, 7'd0, idl.code);
            if (idl.halt) begin
                halt_next = 1'b1;
            end
            if (idl.mode == M_IDENT) begin
                cnt_next = CNT_W'(1);
                pre_next = {32'd0, byte_reg};
            end else if (idl.mode == M_LIT) begin
                cnt_next = CNT_W'(1);
            end
        end
    end

    // Pack the pending-token result ahead of the second one (a freshly scanned token or EOF) and flag the last.
    always_comb
    begin
        r0     = fa_v ? fa : fb;
        r1     = fb;
        n_push = 2'(fa_v) + 2'(fb_v);
        if (n_push == 2'd2) begin
            r1.last = 1'b1;
        end else begin
            r0.last = 1'b1;
        end
    end

    assign head_next  = pop ? head_reg + 2'd1 : head_reg;
    assign tail_next  = tail_reg + n_push;
    assign count_next = count_reg + 3'(n_push) - 3'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg <= 1'b0;
            mode_reg    <= M_IDLE;
            cnt_reg     <= '0;
            pre_reg     <= '0;
            halt_reg    <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
        end else begin
            in_full_reg <= in_full_next;
            mode_reg    <= mode_next;
            cnt_reg     <= cnt_next;
            pre_reg     <= pre_next;
            halt_reg    <= halt_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            byte_reg <= input_byte;
            eoi_reg  <= end_of_input;
        end
        if (n_push != 2'd0) begin
            fifo_reg[tail_reg] <= r0;
        end
        if (n_push == 2'd2) begin
            fifo_reg[tail_reg + 2'd1] <= r1;
        end
    end

endmodule

@@ hw/rtl/ctscan_checker.sv @@
`timescale 1ns / 1ps
`include "calculator_token_scanner_core_macros.svh"

module ctscan_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [4:0] token_kind,
    input logic [6:0] token_length,
    input logic [1:0] error_code,
    input logic       last_result
);
    import ctscan_pkg::*;

    `CTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(token_kind) && $stable(token_length) &&
        $stable(error_code) && $stable(last_result), "stalled token changed")
    `CTS_ASSERT_NOW(a_kind_range, out_valid, token_kind <= K_ERR, "token kind out of range")
    `CTS_ASSERT_NOW(a_err_code, out_valid,
        (token_kind == K_ERR) == (error_code != E_NONE), "error code does not match kind")
    `CTS_ASSERT_NOW(a_len_zero, out_valid && token_kind > K_LIT,
        token_length == 7'd0, "length on a non-text token")
    `CTS_ASSERT_NOW(a_err_last, out_valid && token_kind == K_ERR,
        last_result, "error token not last")

endmodule

bind calculator_token_scanner_core ctscan_checker u_ctscan_checker (.*);

@@ bench/calculator_token_scanner_core_tb.sv @@
`timescale 1ns / 1ps

module calculator_token_scanner_core_tb;

    import ctscan_pkg::*;

    localparam logic [4:0] KIND_READ  = 5'd0;
    localparam logic [4:0] KIND_WRITE = 5'd1;
    localparam logic [4:0] KIND_IF    = 5'd2;
    localparam logic [4:0] KIND_DO    = 5'd3;
    localparam logic [4:0] KIND_FI    = 5'd4;
    localparam logic [4:0] KIND_OD    = 5'd5;
    localparam logic [4:0] KIND_CHECK = 5'd6;

    localparam logic [39:0] TEXT_READ  = 40'h00_64_61_65_72;
    localparam logic [39:0] TEXT_WRITE = 40'h65_74_69_72_77;
    localparam logic [39:0] TEXT_IF    = 40'h00_00_00_66_69;
    localparam logic [39:0] TEXT_DO    = 40'h00_00_00_6F_64;
    localparam logic [39:0] TEXT_FI    = 40'h00_00_00_69_66;
    localparam logic [39:0] TEXT_OD    = 40'h00_00_00_64_6F;
    localparam logic [39:0] TEXT_CHECK = 40'h6B_63_65_68_63;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] input_byte;
    logic       end_of_input;
    logic       out_valid;
    logic       out_stall;
    logic [4:0] token_kind;
    logic [6:0] token_length;
    logic [1:0] error_code;
    logic       last_result;

    calculator_token_scanner_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .input_byte   (input_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_length (token_length),
        .error_code   (error_code),
        .last_result  (last_result)
    );

    result_t           expected_tokens[$];
    logic [MODE_W-1:0] sc_mode;
    logic [39:0]       sc_prefix;
    int                sc_count;
    logic              sc_halted;
    int                step_tokens;
    int                fail_count;
    int                burst_left;
    int                bytes_sent;
    int                stall_hold;
    int                stall_style;
    int                stall_cycles;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic letter_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [4:0] keyword_kind(input logic [39:0] text, input int len);
        if (len == 4 && text == TEXT_READ) return KIND_READ;
        if (len == 5 && text == TEXT_WRITE) return KIND_WRITE;
        if (len == 2 && text == TEXT_IF) return KIND_IF;
        if (len == 2 && text == TEXT_DO) return KIND_DO;
        if (len == 2 && text == TEXT_FI) return KIND_FI;
        if (len == 2 && text == TEXT_OD) return KIND_OD;
        if (len == 5 && text == TEXT_CHECK) return KIND_CHECK;
        return K_ID;
    endfunction

    task automatic emit_token(input logic [4:0] kind, input logic [6:0] len,
                              input logic [1:0] code);
        result_t r;
        r.kind   = kind;
        r.length = len;
        r.code   = code;
        r.last   = 1'b0;
        expected_tokens.push_back(r);
        step_tokens++;
    endtask

    task automatic halt_scan(input logic [1:0] code);
        sc_halted = 1'b1;
        sc_mode   = M_IDLE;
        emit_token(K_ERR, 7'd0, code);
    endtask

    task automatic close_ident();
        sc_mode = M_IDLE;
        emit_token(keyword_kind(sc_prefix, sc_count), 7'(sc_count), E_NONE);
    endtask

    task automatic extend_token(input logic [7:0] c);
        if (sc_count >= MAX_TOKEN_LEN)
        begin
            halt_scan(E_TOO_LONG);
        end
        else
        begin
            if (sc_count < 5) sc_prefix = sc_prefix | (40'(c) << (8 * sc_count));
            sc_count++;
        end
    endtask

    task automatic start_token(input logic [7:0] c);
        sc_mode = M_IDLE;
        if (blank_char(c))
        begin
        end
        else if (letter_char(c))
        begin
            sc_mode   = M_IDENT;
            sc_count  = 1;
            sc_prefix = 40'(c);
        end
        else if (digit_char(c))
        begin
            sc_mode  = M_LIT;
            sc_count = 1;
        end
        else
        begin
            case (c)
                CH_COLON:   sc_mode = M_COLON;
                CH_DOLLAR:  sc_mode = M_DOLLAR;
                CH_EQUAL:   sc_mode = M_EQUAL;
                CH_LESS:    sc_mode = M_LESS;
                CH_GREATER: sc_mode = M_GREATER;
                CH_PLUS:    emit_token(K_ADD, 7'd0, E_NONE);
                CH_MINUS:   emit_token(K_SUB, 7'd0, E_NONE);
                CH_STAR:    emit_token(K_MUL, 7'd0, E_NONE);
                CH_SLASH:   emit_token(K_DIV, 7'd0, E_NONE);
                CH_LPAREN:  emit_token(K_LP, 7'd0, E_NONE);
                CH_RPAREN:  emit_token(K_RP, 7'd0, E_NONE);
                default:    halt_scan(E_BAD_CHAR);
            endcase
        end
    endtask

    task automatic predict_tokens(input logic [7:0] c, input logic eoi);
        result_t r;
        step_tokens = 0;
        if (!sc_halted)
        begin
            if (eoi)
            begin
                case (sc_mode)
                    M_IDENT:   close_ident();
                    M_LIT:     emit_token(K_LIT, 7'(sc_count), E_NONE);
                    M_LESS:    emit_token(K_LT, 7'd0, E_NONE);
                    M_GREATER: emit_token(K_GT, 7'd0, E_NONE);
                    M_COLON, M_DOLLAR, M_EQUAL: halt_scan(E_BAD_PAIR);
                    default: ;
                endcase
                sc_mode = M_IDLE;
                if (!sc_halted) emit_token(K_EOF, 7'd0, E_NONE);
            end
            else
            begin
                case (sc_mode)
                    M_IDENT:
                    begin
                        if (letter_char(c) || digit_char(c) || c == CH_UNDERSCORE)
                        begin
                            extend_token(c);
                        end
                        else
                        begin
                            close_ident();
                            start_token(c);
                        end
                    end
                    M_LIT:
                    begin
                        if (digit_char(c))
                        begin
                            extend_token(c);
                        end
                        else
                        begin
                            sc_mode = M_IDLE;
                            emit_token(K_LIT, 7'(sc_count), E_NONE);
                            start_token(c);
                        end
                    end
                    M_COLON:
                    begin
                        if (c == CH_EQUAL)
                        begin
                            sc_mode = M_IDLE;
                            emit_token(K_GETS, 7'd0, E_NONE);
                        end
                        else
                        begin
                            halt_scan(E_BAD_PAIR);
                        end
                    end
                    M_DOLLAR:
                    begin
                        if (c == CH_DOLLAR)
                        begin
                            sc_mode = M_IDLE;
                            emit_token(K_EOF, 7'd0, E_NONE);
                        end
                        else
                        begin
                            halt_scan(E_BAD_PAIR);
                        end
                    end
                    M_EQUAL:
                    begin
                        if (c == CH_EQUAL)
                        begin
                            sc_mode = M_IDLE;
                            emit_token(K_EQEQ, 7'd0, E_NONE);
                        end
                        else
                        begin
                            halt_scan(E_BAD_PAIR);
                        end
                    end
                    M_LESS:
                    begin
                        sc_mode = M_IDLE;
                        if (c == CH_GREATER)
                        begin
                            emit_token(K_NE, 7'd0, E_NONE);
                        end
                        else if (c == CH_EQUAL)
                        begin
                            emit_token(K_LE, 7'd0, E_NONE);
                        end
                        else
                        begin
                            emit_token(K_LT, 7'd0, E_NONE);
                            start_token(c);
                        end
                    end
                    M_GREATER:
                    begin
                        sc_mode = M_IDLE;
                        if (c == CH_EQUAL)
                        begin
                            emit_token(K_GE, 7'd0, E_NONE);
                        end
                        else
                        begin
                            emit_token(K_GT, 7'd0, E_NONE);
                            start_token(c);
                        end
                    end
                    default: start_token(c);
                endcase
            end
        end
        if (step_tokens > 0)
        begin
            r = expected_tokens.pop_back();
            r.last = 1'b1;
            expected_tokens.push_back(r);
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic eoi);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid     <= 1'b1;
        input_byte   <= b;
        end_of_input <= eoi;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        predict_tokens(b, eoi);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    function automatic string keyword_word(input int i);
        case (i)
            0: return "read";
            1: return "write";
            2: return "if";
            3: return "do";
            4: return "fi";
            5: return "od";
            default: return "check";
        endcase
    endfunction

    function automatic string operator_word(input int i);
        case (i)
            0: return ":=";
            1: return "==";
            2: return "<>";
            3: return "<=";
            4: return "<";
            5: return ">=";
            6: return ">";
            7: return "+";
            8: return "-";
            9: return "*";
            10: return "/";
            11: return "(";
            12: return ")";
            default: return "$$";
        endcase
    endfunction

    function automatic logic [7:0] ident_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26) return 8'h61 + 8'(r);
        if (r < 52) return 8'h41 + 8'(r - 26);
        if (r < 62) return 8'h30 + 8'(r - 52);
        return CH_UNDERSCORE;
    endfunction

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    // valid characters that never open a ':', '$' or '=' pair
    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 4))
            0: return ident_char();
            1: return blank_byte();
            2: return 8'h30 + 8'($urandom_range(0, 9));
            3:
            begin
                case ($urandom_range(0, 7))
                    0: return CH_PLUS;
                    1: return CH_MINUS;
                    2: return CH_STAR;
                    3: return CH_SLASH;
                    4: return CH_LPAREN;
                    5: return CH_RPAREN;
                    6: return CH_LESS;
                    default: return CH_GREATER;
                endcase
            end
            default: return ($urandom_range(0, 1) != 0) ? CH_LESS : CH_GREATER;
        endcase
    endfunction

    function automatic logic [7:0] invalid_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (letter_char(c) || digit_char(c) || blank_char(c) || c == CH_COLON ||
               c == CH_DOLLAR || c == CH_EQUAL || c == CH_LESS || c == CH_GREATER ||
               c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               c == CH_LPAREN || c == CH_RPAREN)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic send_random_token();
        int pick;
        int len;
        string w;
        if ((sc_mode == M_IDENT || sc_mode == M_LIT) && sc_count > 80) send_item(CH_SPACE, 1'b0);
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            send_text(keyword_word($urandom_range(0, 6)));
            if ($urandom_range(0, 3) != 0) send_item(blank_byte(), 1'b0);
        end
        else if (pick < 35)
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 8);
            send_item(($urandom_range(0, 1) != 0) ? 8'h61 + 8'($urandom_range(0, 25))
                                                  : 8'h41 + 8'($urandom_range(0, 25)), 1'b0);
            for (int i = 1; i < len; i++) send_item(ident_char(), 1'b0);
        end
        else if (pick < 50)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) send_item(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
        end
        else if (pick < 70)
        begin
            w = operator_word($urandom_range(0, 13));
            // hold off a leading '=' that a pending '<' or '>' would swallow
            if (w[0] == CH_EQUAL && (sc_mode == M_LESS || sc_mode == M_GREATER))
                send_item(CH_SPACE, 1'b0);
            send_text(w);
        end
        else if (pick < 85)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) send_item(blank_byte(), 1'b0);
        end
        else if (pick < 93)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            send_item(noise_char(), 1'b0);
        end
    endtask

    task automatic test_operators();
        send_text(":===<><=<+>=>-*/()$$");
        send_item(8'h7A, 1'b0);
        send_item(8'h39, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h30, 1'b0);
        send_item(8'h80, 1'b1);
    endtask

    task automatic test_long_tokens();
        send_item(CH_SPACE, 1'b0);
        send_item(8'h5A, 1'b0);
        for (int i = 1; i < MAX_TOKEN_LEN; i++) send_item(ident_char(), 1'b0);
        send_item(CH_PLUS, 1'b0);
        for (int i = 0; i < MAX_TOKEN_LEN; i++) send_item(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
        send_item(CH_LESS, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(CH_GREATER, 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    task automatic test_random_programs();
        int stop_at;
        stop_at = bytes_sent + 280;
        while (bytes_sent < stop_at) send_random_token();
    endtask

    task automatic test_halt();
        logic [7:0] c;
        send_item(CH_SPACE, 1'b0);
        case ($urandom_range(0, 6))
            0:
            begin
                send_item(CH_COLON, 1'b0);
                c = 8'($urandom_range(0, 255));
                if (c == CH_EQUAL) c = CH_COLON;
                send_item(c, 1'b0);
            end
            1:
            begin
                send_item(CH_EQUAL, 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
            2:
            begin
                send_item(CH_DOLLAR, 1'b0);
                c = 8'($urandom_range(0, 255));
                if (c == CH_DOLLAR) c = CH_EQUAL;
                send_item(c, 1'b0);
            end
            3:
            begin
                send_item(($urandom_range(0, 1) != 0) ? CH_COLON : CH_DOLLAR, 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
            4:
            begin
                send_item(8'h61, 1'b0);
                for (int i = 1; i <= MAX_TOKEN_LEN; i++) send_item(ident_char(), 1'b0);
            end
            5:
            begin
                for (int i = 0; i <= MAX_TOKEN_LEN; i++)
                    send_item(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
            end
            default:
            begin
                send_text("x1");
                send_item(invalid_char(), 1'b0);
            end
        endcase
        for (int i = 0; i < 20; i++)
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    always @(posedge clk)
    begin
        result_t want;
        logic    next_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected token: kind %0d length %0d code %0d last %0d",
                           token_kind, token_length, error_code, last_result);
                    fail_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token_kind !== want.kind)
                    begin
                        $error("token_kind: expected %0d, actual %0d", want.kind, token_kind);
                        fail_count++;
                    end
                    if (token_length !== want.length)
                    begin
                        $error("token_length: expected %0d, actual %0d",
                               want.length, token_length);
                        fail_count++;
                    end
                    if (error_code !== want.code)
                    begin
                        $error("error_code: expected %0d, actual %0d", want.code, error_code);
                        fail_count++;
                    end
                    if (last_result !== want.last)
                    begin
                        $error("last_result: expected %0d, actual %0d",
                               want.last, last_result);
                        fail_count++;
                    end
                end
            end
            stall_cycles++;
            if (stall_cycles >= 150)
            begin
                stall_cycles = 0;
                stall_style  = $urandom_range(0, 2);
            end
            if (stall_hold > 0)
            begin
                stall_hold--;
                next_stall = 1'b1;
            end
            else
            begin
                case (stall_style)
                    0: next_stall = 1'b0;
                    1: next_stall = ($urandom_range(0, 3) == 0);
                    default:
                    begin
                        next_stall = ($urandom_range(0, 5) == 0);
                        if (next_stall) stall_hold = $urandom_range(1, 8);
                    end
                endcase
            end
            out_stall <= next_stall;
        end
    end

    initial
    begin
        #5000000;
        $display("calculator_token_scanner_core verification failed");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        input_byte   = 8'h00;
        end_of_input = 1'b0;
        out_stall    = 1'b0;
        sc_mode      = M_IDLE;
        sc_prefix    = 40'd0;
        sc_count     = 0;
        sc_halted    = 1'b0;
        step_tokens  = 0;
        fail_count   = 0;
        burst_left   = 0;
        bytes_sent   = 0;
        stall_hold   = 0;
        stall_style  = 0;
        stall_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_operators();
        test_long_tokens();
        test_random_programs();
        test_halt();
        in_valid <= 1'b0;

        while (expected_tokens.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("calculator_token_scanner_core verification clean");
        end
        else
        begin
            $display("calculator_token_scanner_core verification failed");
        end
        $finish;
    end

endmodule
